// ===== sv/tsna_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the triangle setup pipeline.
package tsna_pkg;

  localparam int COORD_W   = 24;
  localparam int NORM_W    = 16;
  localparam int NORM_FRAC = 14;
  localparam int JAC_W     = 50;

  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int HALF_W  = MAG_W / 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int LEN_W   = 6;

  // the largest normalized component sits in [2^61, 2^62)
  localparam int NV_W   = 62;
  localparam int RAD_W  = 2 * NV_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int QUO_W  = NORM_FRAC + 1;
  localparam int DEN_W  = ROOT_W + 1;
  localparam int NUM_W  = NV_W + QUO_W + 1;

  // centroid: floor(x / 3) = (x * CREC) >> CREC_SHIFT for x < 2^CMAG_W
  localparam int CSUM_W     = COORD_W + 2;
  localparam int CMAG_W     = COORD_W + 1;
  localparam int CREC_SHIFT = CMAG_W + 1;
  localparam logic [CMAG_W-1:0] CREC =
    CMAG_W'(((64'd1 << CREC_SHIFT) + 64'd2) / 64'd3);

  localparam logic [JAC_W-1:0]  JAC_MAX  = {JAC_W{1'b1}};
  localparam logic [NORM_W-1:0] NORM_SAT = {1'b0, {(NORM_W - 1){1'b1}}};
  localparam logic signed [CMAG_W-1:0] CEN_MAX =
    CMAG_W'({1'b0, {(COORD_W - 1){1'b1}}});

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex0_x;
    logic signed [COORD_W-1:0] vertex0_y;
    logic signed [COORD_W-1:0] vertex0_z;
    logic signed [COORD_W-1:0] vertex1_x;
    logic signed [COORD_W-1:0] vertex1_y;
    logic signed [COORD_W-1:0] vertex1_z;
    logic signed [COORD_W-1:0] vertex2_x;
    logic signed [COORD_W-1:0] vertex2_y;
    logic signed [COORD_W-1:0] vertex2_z;
  } vtx_word_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic [JAC_W-1:0]          jacobian;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic signed [COORD_W-1:0] centroid_z;
    logic                      degenerate;
  } res_word_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

endpackage

// ===== sv/tsna_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one root bit per stage.
module tsna_sqrt #(
  parameter int RAD_W  = tsna_pkg::RAD_W,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  tsna_pkg::pipe_ctl_t ctl,
  input  logic [RAD_W-1:0]    rad,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                valid,
  output logic [RAD_W/2-1:0]  root,
  output logic [RAD_W/2:0]    rem,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int TRY_W  = REM_W + 2;

  logic              stg_valid [ROOT_W+1];
  logic [RAD_W-1:0]  stg_rad   [ROOT_W+1];
  logic [ROOT_W-1:0] stg_root  [ROOT_W+1];
  logic [REM_W-1:0]  stg_rem   [ROOT_W+1];
  logic [SIDE_W-1:0] stg_side  [ROOT_W+1];

  logic [ROOT_W-1:0] root_next [ROOT_W];
  logic [REM_W-1:0]  rem_next  [ROOT_W];

  assign stg_valid[0] = ctl.valid;
  assign stg_rad[0]   = rad;
  assign stg_root[0]  = '0;
  assign stg_rem[0]   = '0;
  assign stg_side[0]  = side_in;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [TRY_W-1:0] acc;
    logic [TRY_W-1:0] trial;
    logic             fit;
    always_comb begin
      acc          = {stg_rem[j], stg_rad[j][RAD_W-1-2*j -: 2]};
      trial        = TRY_W'({stg_root[j], 2'b01});
      fit          = (acc >= trial);
      rem_next[j]  = fit ? REM_W'(acc - trial) : REM_W'(acc);
      root_next[j] = {stg_root[j][ROOT_W-2:0], fit};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[j+1] <= 1'b0;
      end else if (ctl.advance) begin
        stg_valid[j+1] <= stg_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        stg_rad[j+1]  <= stg_rad[j];
        stg_root[j+1] <= root_next[j];
        stg_rem[j+1]  <= rem_next[j];
        stg_side[j+1] <= stg_side[j];
      end
    end
  end

  assign valid    = stg_valid[ROOT_W];
  assign root     = stg_root[ROOT_W];
  assign rem      = stg_rem[ROOT_W];
  assign side_out = stg_side[ROOT_W];

endmodule

// ===== sv/tsna_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, lanes share one divisor, one quotient bit per stage.
module tsna_div #(
  parameter int LANES  = 3,
  parameter int NUM_W  = tsna_pkg::NUM_W,
  parameter int DEN_W  = tsna_pkg::DEN_W,
  parameter int QUO_W  = tsna_pkg::QUO_W,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tsna_pkg::pipe_ctl_t              ctl,
  input  logic [LANES-1:0][NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]                 den,
  input  logic [SIDE_W-1:0]                side_in,
  output logic                             valid,
  output logic [LANES-1:0][QUO_W-1:0]      quo,
  output logic [SIDE_W-1:0]                side_out
);

  logic                          stg_valid [QUO_W+1];
  logic [LANES-1:0][NUM_W-1:0]   stg_rem   [QUO_W+1];
  logic [LANES-1:0][QUO_W-1:0]   stg_quo   [QUO_W+1];
  logic [DEN_W-1:0]              stg_den   [QUO_W+1];
  logic [SIDE_W-1:0]             stg_side  [QUO_W+1];

  logic [LANES-1:0][NUM_W-1:0]   rem_next  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]   quo_next  [QUO_W];

  assign stg_valid[0] = ctl.valid;
  assign stg_rem[0]   = num;
  assign stg_quo[0]   = '0;
  assign stg_den[0]   = den;
  assign stg_side[0]  = side_in;

  // quotient is known to stay below 2^QUO_W
  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [NUM_W-1:0] trial;
    logic [LANES-1:0] fit;
    always_comb begin
      trial = NUM_W'(stg_den[j]) << (QUO_W - 1 - j);
      for (int l = 0; l < LANES; l++) begin
        fit[l]         = (stg_rem[j][l] >= trial);
        rem_next[j][l] = fit[l] ? stg_rem[j][l] - trial : stg_rem[j][l];
        quo_next[j][l] = {stg_quo[j][l][QUO_W-2:0], fit[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[j+1] <= 1'b0;
      end else if (ctl.advance) begin
        stg_valid[j+1] <= stg_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        stg_rem[j+1]  <= rem_next[j];
        stg_quo[j+1]  <= quo_next[j];
        stg_den[j+1]  <= stg_den[j];
        stg_side[j+1] <= stg_side[j];
      end
    end
  end

  assign valid    = stg_valid[QUO_W];
  assign quo      = stg_quo[QUO_W];
  assign side_out = stg_side[QUO_W];

endmodule

// ===== sv/triangle_setup_normal_area.sv =====
`timescale 1ns / 1ps
// Triangle setup top level: unit normal, Jacobian and centroid pipeline.
//
// Usage notes:
// - Input channel vtx_*: one word holds the three vertices of a triangle,
//   signed Q12.12. A word is taken on a rising edge with vtx_valid high and
//   vtx_stall low.
// - Output channel res_*: one word per triangle, in input order: unit normal
//   (Q1.14, round to nearest), Jacobian |e1 x e2| (Q26.24), centroid (Q12.12)
//   and a degenerate flag (zero cross product, normal and Jacobian zero).
// - Throughput: one triangle per cycle, sustained while res_stall is low.
// - Pipeline: 88 register stages. Stages: 7 setup stages (edges, products,
//   cross terms, square partials, squares, square sum, normalize), 63
//   stages of the root unit (one root bit each), 1 rounding stage, 15
//   divider stages (one quotient bit each), 1 final stage and the output
//   register.
// - Stall: all stages before the output register advance together. The output
//   register holds a word until it is taken; the pipeline keeps moving (and
//   vtx_stall stays low) until its last stage also holds a finished word.
// - Reset (rst, synchronous) clears all valid bits; payload is not reset.
module triangle_setup_normal_area (
  input  logic                clk,
  input  logic                rst,
  input  logic                vtx_valid,
  output logic                vtx_stall,
  input  tsna_pkg::vtx_word_t vtx_word,
  output logic                res_valid,
  input  logic                res_stall,
  output tsna_pkg::res_word_t res_word
);

  localparam int COORD_W = tsna_pkg::COORD_W;
  localparam int EDGE_W  = tsna_pkg::EDGE_W;
  localparam int PROD_W  = tsna_pkg::PROD_W;
  localparam int CROSS_W = tsna_pkg::CROSS_W;
  localparam int MAG_W   = tsna_pkg::MAG_W;
  localparam int HALF_W  = tsna_pkg::HALF_W;
  localparam int SQ_W    = tsna_pkg::SQ_W;
  localparam int SUM_W   = tsna_pkg::SUM_W;
  localparam int LEN_W   = tsna_pkg::LEN_W;
  localparam int NV_W    = tsna_pkg::NV_W;
  localparam int RAD_W   = tsna_pkg::RAD_W;
  localparam int ROOT_W  = tsna_pkg::ROOT_W;
  localparam int REM_W   = tsna_pkg::REM_W;
  localparam int QUO_W   = tsna_pkg::QUO_W;
  localparam int DEN_W   = tsna_pkg::DEN_W;
  localparam int NUM_W   = tsna_pkg::NUM_W;
  localparam int CSUM_W  = tsna_pkg::CSUM_W;
  localparam int CMAG_W  = tsna_pkg::CMAG_W;
  localparam int NORM_W  = tsna_pkg::NORM_W;
  localparam int JAC_W   = tsna_pkg::JAC_W;

  // side data carried through the root unit
  typedef struct packed {
    logic [2:0][NV_W-1:0]    nv;
    logic [LEN_W-1:0]        k;
    logic                    degen;
    logic [2:0]              neg;
    logic [2:0][COORD_W-1:0] cen;
  } sq_side_t;

  // side data carried through the divider
  typedef struct packed {
    logic [JAC_W-1:0]        jac;
    logic                    degen;
    logic [2:0]              neg;
    logic [2:0][COORD_W-1:0] cen;
  } dv_side_t;

  // ---------------------------------------------------------------- flow
  logic fin_valid;
  logic advance;
  logic take;

  assign take      = !res_valid || !res_stall;
  assign advance   = !(fin_valid && res_valid && res_stall);
  assign vtx_stall = !advance;

  // ------------------------------------------------- stage 1: edges, sums
  logic signed [COORD_W-1:0] v0 [3];
  logic signed [COORD_W-1:0] v1 [3];
  logic signed [COORD_W-1:0] v2 [3];

  assign v0[0] = vtx_word.vertex0_x;
  assign v0[1] = vtx_word.vertex0_y;
  assign v0[2] = vtx_word.vertex0_z;
  assign v1[0] = vtx_word.vertex1_x;
  assign v1[1] = vtx_word.vertex1_y;
  assign v1[2] = vtx_word.vertex1_z;
  assign v2[0] = vtx_word.vertex2_x;
  assign v2[1] = vtx_word.vertex2_y;
  assign v2[2] = vtx_word.vertex2_z;

  logic                     s1_valid;
  logic signed [EDGE_W-1:0] s1_e1   [3];
  logic signed [EDGE_W-1:0] s1_e2   [3];
  logic signed [CSUM_W-1:0] s1_csum [3];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s1_e1[i]   <= EDGE_W'(v1[i]) - EDGE_W'(v0[i]);
        s1_e2[i]   <= EDGE_W'(v2[i]) - EDGE_W'(v0[i]);
        s1_csum[i] <= CSUM_W'(v0[i]) + CSUM_W'(v1[i]) + CSUM_W'(v2[i]);
      end
    end
  end

  // ------------------------------------ stage 2: cross products, 1/3 scale
  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_pa [3];
  logic signed [PROD_W-1:0] s2_pb [3];
  logic [2:0]               s2_cneg;
  logic [2*CMAG_W-1:0]      s2_cprod [3];

  logic [CSUM_W-1:0] cabs [3];
  logic [CMAG_W-1:0] cinc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cabs[i] = s1_csum[i][CSUM_W-1] ? CSUM_W'(-s1_csum[i]) : CSUM_W'(s1_csum[i]);
      // +1 gives round to nearest once divided by three
      cinc[i] = CMAG_W'(cabs[i]) + CMAG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pa[0] <= s1_e1[1] * s1_e2[2];
      s2_pb[0] <= s1_e1[2] * s1_e2[1];
      s2_pa[1] <= s1_e1[2] * s1_e2[0];
      s2_pb[1] <= s1_e1[0] * s1_e2[2];
      s2_pa[2] <= s1_e1[0] * s1_e2[1];
      s2_pb[2] <= s1_e1[1] * s1_e2[0];
      for (int i = 0; i < 3; i++) begin
        s2_cneg[i]  <= s1_csum[i][CSUM_W-1];
        s2_cprod[i] <= (2*CMAG_W)'(cinc[i]) * (2*CMAG_W)'(tsna_pkg::CREC);
      end
    end
  end

  // --------------------------------- stage 3: cross terms, centroid result
  logic                    s3_valid;
  logic [2:0][MAG_W-1:0]   s3_mag;
  logic [2:0]              s3_neg;
  logic [2:0][COORD_W-1:0] s3_cen;

  logic signed [CROSS_W-1:0] cr   [3];
  logic signed [CMAG_W-1:0]  cq   [3];
  logic signed [CMAG_W-1:0]  csat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = CROSS_W'(s2_pa[i]) - CROSS_W'(s2_pb[i]);
      cq[i] = $signed(CMAG_W'(s2_cprod[i][tsna_pkg::CREC_SHIFT +: COORD_W]));
      if (s2_cneg[i]) cq[i] = -cq[i];
      csat[i] = (cq[i] > tsna_pkg::CEN_MAX) ? tsna_pkg::CEN_MAX : cq[i];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s3_neg[i] <= cr[i][CROSS_W-1];
        s3_mag[i] <= cr[i][CROSS_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
        s3_cen[i] <= COORD_W'(csat[i]);
      end
    end
  end

  // ------------------------------- stage 4: square partials, bit length
  logic                     s4_valid;
  logic [2:0][2*HALF_W-1:0] s4_hh;
  logic [2:0][2*HALF_W-1:0] s4_hl;
  logic [2:0][2*HALF_W-1:0] s4_ll;
  logic [LEN_W-1:0]         s4_len;
  logic [2:0][MAG_W-1:0]    s4_mag;
  logic [2:0]               s4_neg;
  logic [2:0][COORD_W-1:0]  s4_cen;

  logic [MAG_W-1:0] ormag;
  logic [LEN_W-1:0] len;

  always_comb begin
    ormag = s3_mag[0] | s3_mag[1] | s3_mag[2];
    len   = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (ormag[b]) len = LEN_W'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s4_hh[i] <= (2*HALF_W)'(s3_mag[i][MAG_W-1 -: HALF_W])
                    * (2*HALF_W)'(s3_mag[i][MAG_W-1 -: HALF_W]);
        s4_hl[i] <= (2*HALF_W)'(s3_mag[i][MAG_W-1 -: HALF_W])
                    * (2*HALF_W)'(s3_mag[i][HALF_W-1:0]);
        s4_ll[i] <= (2*HALF_W)'(s3_mag[i][HALF_W-1:0])
                    * (2*HALF_W)'(s3_mag[i][HALF_W-1:0]);
      end
      s4_len <= len;
      s4_mag <= s3_mag;
      s4_neg <= s3_neg;
      s4_cen <= s3_cen;
    end
  end

  // --------------------------------------- stage 5: squares, shift count
  logic                    s5_valid;
  logic [2:0][SQ_W-1:0]    s5_sq;
  logic [LEN_W-1:0]        s5_k;
  logic                    s5_degen;
  logic [2:0][MAG_W-1:0]   s5_mag;
  logic [2:0]              s5_neg;
  logic [2:0][COORD_W-1:0] s5_cen;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq[i] <= (SQ_W'(s4_hh[i]) << (2 * HALF_W))
                    + (SQ_W'(s4_hl[i]) << (HALF_W + 1))
                    + SQ_W'(s4_ll[i]);
      end
      // left shift that puts the top set bit at position NV_W-1
      s5_k     <= LEN_W'(NV_W) - s4_len;
      s5_degen <= (s4_len == '0);
      s5_mag   <= s4_mag;
      s5_neg   <= s4_neg;
      s5_cen   <= s4_cen;
    end
  end

  // ---------------------------------------------- stage 6: sum of squares
  logic                    s6_valid;
  logic [SUM_W-1:0]        s6_sum;
  logic [LEN_W-1:0]        s6_k;
  logic                    s6_degen;
  logic [2:0][MAG_W-1:0]   s6_mag;
  logic [2:0]              s6_neg;
  logic [2:0][COORD_W-1:0] s6_cen;

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_sum   <= SUM_W'(s5_sq[0]) + SUM_W'(s5_sq[1]) + SUM_W'(s5_sq[2]);
      s6_k     <= s5_k;
      s6_degen <= s5_degen;
      s6_mag   <= s5_mag;
      s6_neg   <= s5_neg;
      s6_cen   <= s5_cen;
    end
  end

  // ------------------------------------------------- stage 7: normalize
  logic             s7_valid;
  logic [RAD_W-1:0] s7_rad;
  sq_side_t         s7_side;

  always_ff @(posedge clk) begin
    if (advance) begin
      // shifting the squared sum by 2k equals squaring the shifted parts
      s7_rad <= RAD_W'(s6_sum) << {s6_k, 1'b0};
      for (int i = 0; i < 3; i++) s7_side.nv[i] <= NV_W'(s6_mag[i]) << s6_k;
      s7_side.k     <= s6_k;
      s7_side.degen <= s6_degen;
      s7_side.neg   <= s6_neg;
      s7_side.cen   <= s6_cen;
    end
  end

  // -------------------------------------------------------- root unit
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [REM_W-1:0]  sq_rem;
  sq_side_t          sq_side;
  tsna_pkg::pipe_ctl_t sq_ctl;

  assign sq_ctl.valid   = s7_valid;
  assign sq_ctl.advance = advance;

  tsna_sqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sq_ctl),
    .rad      (s7_rad),
    .side_in  (s7_side),
    .valid    (sq_valid),
    .root     (sq_root),
    .rem      (sq_rem),
    .side_out (sq_side)
  );

  // ---------------------------------- stage 8: rounding of both roots
  // root = floor(sqrt(S) * 2^k): the rounded normalized root adds one when
  // the remainder exceeds it; the Jacobian is floor(2 sqrt(S)) rounded up
  // by half, read from bit k-1 upward.
  logic                        s8_valid;
  logic [2:0][NUM_W-1:0]       s8_num;
  logic [DEN_W-1:0]            s8_den;
  dv_side_t                    s8_side;

  logic [ROOT_W-1:0] jn;
  logic [ROOT_W-1:0] jhalf;
  logic [ROOT_W-1:0] jround;
  logic [JAC_W-1:0]  jac;

  always_comb begin
    jn     = sq_root + ROOT_W'(sq_rem > REM_W'(sq_root));
    jhalf  = sq_root >> (sq_side.k - LEN_W'(1));
    jround = (jhalf + ROOT_W'(1)) >> 1;
    if (sq_side.degen) jac = '0;
    else if (jround > ROOT_W'(tsna_pkg::JAC_MAX)) jac = tsna_pkg::JAC_MAX;
    else jac = JAC_W'(jround);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // round(nv * 2^F / jn) = floor((2 nv 2^F + jn) / (2 jn))
      for (int i = 0; i < 3; i++) begin
        s8_num[i] <= (NUM_W'(sq_side.nv[i]) << QUO_W) + NUM_W'(jn);
      end
      s8_den        <= {jn, 1'b0};
      s8_side.jac   <= jac;
      s8_side.degen <= sq_side.degen;
      s8_side.neg   <= sq_side.neg;
      s8_side.cen   <= sq_side.cen;
    end
  end

  // ------------------------------------------------------------ divider
  logic                   dv_valid;
  logic [2:0][QUO_W-1:0]  dv_quo;
  dv_side_t               dv_side;
  tsna_pkg::pipe_ctl_t    dv_ctl;

  assign dv_ctl.valid   = s8_valid;
  assign dv_ctl.advance = advance;

  tsna_div #(
    .LANES  (3),
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .QUO_W  (QUO_W),
    .SIDE_W ($bits(dv_side_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dv_ctl),
    .num      (s8_num),
    .den      (s8_den),
    .side_in  (s8_side),
    .valid    (dv_valid),
    .quo      (dv_quo),
    .side_out (dv_side)
  );

  // ------------------------------------------- stage 9: sign and assembly
  tsna_pkg::res_word_t fin_word;
  tsna_pkg::res_word_t fin_next;
  logic [NORM_W-1:0]   nq   [3];
  logic [NORM_W-1:0]   nsig [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq[i] = (NORM_W'(dv_quo[i]) > tsna_pkg::NORM_SAT) ? tsna_pkg::NORM_SAT
                                                         : NORM_W'(dv_quo[i]);
      if (dv_side.degen) nsig[i] = '0;
      else if (dv_side.neg[i]) nsig[i] = -nq[i];
      else nsig[i] = nq[i];
    end
    fin_next.normal_x   = $signed(nsig[0]);
    fin_next.normal_y   = $signed(nsig[1]);
    fin_next.normal_z   = $signed(nsig[2]);
    fin_next.jacobian   = dv_side.jac;
    fin_next.centroid_x = $signed(dv_side.cen[0]);
    fin_next.centroid_y = $signed(dv_side.cen[1]);
    fin_next.centroid_z = $signed(dv_side.cen[2]);
    fin_next.degenerate = dv_side.degen;
  end

  always_ff @(posedge clk) begin
    if (advance) fin_word <= fin_next;
  end

  // ----------------------------------------------------- valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      fin_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= vtx_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= sq_valid;
      fin_valid <= dv_valid;
    end
  end

  // ---------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_word <= fin_word;
  end

  // --------------------------------------------------------- assertions
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.degenerate |->
      res_word.normal_x == 0 && res_word.normal_y == 0 &&
      res_word.normal_z == 0 && res_word.jacobian == 0)
    else $error("degenerate word carries nonzero normal or jacobian");

  a_jac_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_word.degenerate |-> res_word.jacobian != 0)
    else $error("nondegenerate triangle with zero jacobian");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      res_word.normal_x <= 16'sd16384 && res_word.normal_x >= -16'sd16384 &&
      res_word.normal_y <= 16'sd16384 && res_word.normal_y >= -16'sd16384 &&
      res_word.normal_z <= 16'sd16384 && res_word.normal_z >= -16'sd16384)
    else $error("normal component beyond unit range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    vtx_stall |-> res_valid && res_stall && fin_valid)
    else $error("input stalled without a full, blocked output");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the triangle setup pipeline.
module tb;

  localparam int COORD_W   = tsna_pkg::COORD_W;
  localparam int NORM_W    = tsna_pkg::NORM_W;
  localparam int NORM_FRAC = tsna_pkg::NORM_FRAC;
  localparam int JAC_W     = tsna_pkg::JAC_W;

  localparam int N_RANDOM   = 900;
  localparam int HOLD_AT    = 450;     // sender waits for a full drain here
  localparam int CYCLE_MAX  = 300000;
  localparam int DRAIN_WAIT = 150;     // beyond the pipeline latency

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                vtx_valid = 1'b0;
  logic                vtx_stall;
  tsna_pkg::vtx_word_t vtx_word = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  tsna_pkg::res_word_t res_word;

  triangle_setup_normal_area DUT (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx_word(vtx_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
  );

  tsna_pkg::vtx_word_t tri_pending[$];
  tsna_pkg::res_word_t setup_expected[$];
  int        n_sent = 0, n_taken = 0, n_total = 0;
  int        n_bad = 0, cycles = 0;
  int        gap_cnt = 0, stall_cnt = 0;
  bit        drained = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    n_bad++;
  endtask

  // round(sqrt(s)), bit-serial restoring root
  function automatic bit [127:0] root_round(input bit [127:0] s);
    bit [127:0] res, b;
    res = '0;
    b = 128'd1 << 126;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    if (s > res) res = res + 1;
    return res;
  endfunction

  // (a+b+c)/3 rounded to nearest, saturated to the coordinate range
  function automatic logic signed [COORD_W-1:0] third_of_sum(input longint a, b, c);
    longint s, m, v;
    s = a + b + c;
    m = ((s < 0 ? -s : s) + 1) / 3;
    v = s < 0 ? -m : m;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[COORD_W-1:0];
  endfunction

  function automatic tsna_pkg::res_word_t predict_setup(input tsna_pkg::vtx_word_t w);
    longint              p[9], e1[3], e2[3], c[3];
    bit [127:0]          mag[3], s, nv[3], jn, q, num;
    int                  len;
    tsna_pkg::res_word_t r;
    p[0] = w.vertex0_x; p[1] = w.vertex0_y; p[2] = w.vertex0_z;
    p[3] = w.vertex1_x; p[4] = w.vertex1_y; p[5] = w.vertex1_z;
    p[6] = w.vertex2_x; p[7] = w.vertex2_y; p[8] = w.vertex2_z;
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[3+i] - p[i];
      e2[i] = p[6+i] - p[i];
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    len = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      for (int b = 0; b < 64; b++) if (mag[i][b] && b + 1 > len) len = b + 1;
    end
    r = '0;
    if (len == 0) begin
      r.degenerate = 1'b1;
    end else begin
      // magnitudes stay below 2^51, so the Jacobian needs no prescale
      s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      jn = root_round(s);
      r.jacobian = (jn > tsna_pkg::JAC_MAX) ? tsna_pkg::JAC_MAX : jn[JAC_W-1:0];
      s = '0;
      for (int i = 0; i < 3; i++) begin
        nv[i] = mag[i] << (62 - len);
        s = s + nv[i] * nv[i];
      end
      jn = root_round(s);
      for (int i = 0; i < 3; i++) begin
        num = nv[i] << NORM_FRAC;
        q = (2 * num + jn) / (2 * jn);
        if (q > 32767) q = 32767;
        if (c[i] < 0) q = -q;
        case (i)
          0: r.normal_x = q[NORM_W-1:0];
          1: r.normal_y = q[NORM_W-1:0];
          default: r.normal_z = q[NORM_W-1:0];
        endcase
      end
    end
    r.centroid_x = third_of_sum(p[0], p[3], p[6]);
    r.centroid_y = third_of_sum(p[1], p[4], p[7]);
    r.centroid_z = third_of_sum(p[2], p[5], p[8]);
    return r;
  endfunction

  // coordinates wrap to the field width
  function automatic tsna_pkg::vtx_word_t make_tri(input longint ax, ay, az, bx, by, bz,
                                                   cx, cy, cz);
    tsna_pkg::vtx_word_t w;
    w.vertex0_x = COORD_W'(ax); w.vertex0_y = COORD_W'(ay); w.vertex0_z = COORD_W'(az);
    w.vertex1_x = COORD_W'(bx); w.vertex1_y = COORD_W'(by); w.vertex1_z = COORD_W'(bz);
    w.vertex2_x = COORD_W'(cx); w.vertex2_y = COORD_W'(cy); w.vertex2_z = COORD_W'(cz);
    return w;
  endfunction

  function automatic logic [COORD_W-1:0] rnd_coord(input int span);
    if (span >= COORD_W) return COORD_W'($urandom);
    return COORD_W'($urandom_range(2 * (1 << span)) - (1 << span));
  endfunction

  // Driver: new word on the falling edge once the current one is taken.
  always @(negedge clk) begin
    logic v;
    v = vtx_valid;
    if (!rst && (!vtx_valid || n_taken == n_sent)) begin
      v = 1'b0;
      if (gap_cnt > 0) begin
        gap_cnt--;
      end else if (n_sent == HOLD_AT && !drained) begin
        // hold off until the pipe is empty
        if (setup_expected.size() == 0) drained = 1'b1;
      end else if (tri_pending.size() > 0) begin
        vtx_word <= tri_pending.pop_front();
        v = 1'b1;
        n_sent++;
        if (n_sent < n_total - 100 && $urandom_range(5) == 0)
          gap_cnt = $urandom_range(12, 1);
      end
    end
    vtx_valid <= v;
    // receiver back-pressure in bursts
    if (stall_cnt > 0) begin
      stall_cnt--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      if (n_sent < n_total - 100 && $urandom_range(7) == 0)
        stall_cnt = $urandom_range(12, 1);
    end
  end

  // Monitor: both channels sampled on the rising edge.
  always @(posedge clk) begin
    tsna_pkg::res_word_t e;
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst) begin
      if (vtx_valid && !vtx_stall) begin
        setup_expected.push_back(predict_setup(vtx_word));
        n_taken++;
      end
      if (res_valid && !res_stall) begin
        if (setup_expected.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          e = setup_expected.pop_front();
          if (res_word.normal_x !== e.normal_x)
            report($sformatf("normal_x %0d exp %0d", res_word.normal_x, e.normal_x));
          if (res_word.normal_y !== e.normal_y)
            report($sformatf("normal_y %0d exp %0d", res_word.normal_y, e.normal_y));
          if (res_word.normal_z !== e.normal_z)
            report($sformatf("normal_z %0d exp %0d", res_word.normal_z, e.normal_z));
          if (res_word.jacobian !== e.jacobian)
            report($sformatf("jacobian %0d exp %0d", res_word.jacobian, e.jacobian));
          if (res_word.centroid_x !== e.centroid_x)
            report($sformatf("centroid_x %0d exp %0d", res_word.centroid_x,
                             e.centroid_x));
          if (res_word.centroid_y !== e.centroid_y)
            report($sformatf("centroid_y %0d exp %0d", res_word.centroid_y,
                             e.centroid_y));
          if (res_word.centroid_z !== e.centroid_z)
            report($sformatf("centroid_z %0d exp %0d", res_word.centroid_z,
                             e.centroid_z));
          if (res_word.degenerate !== e.degenerate)
            report($sformatf("degenerate %0b exp %0b", res_word.degenerate,
                             e.degenerate));
        end
      end
    end
  end

  initial begin
    longint mx, mn, ax, ay, az, dx, dy, dz;
    int     k, span;
    mx = 8388607;
    mn = -8388608;
    // directed: extremes, axis-aligned normals, degenerate shapes
    tri_pending.push_back(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    tri_pending.push_back(make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_pending.push_back(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
    tri_pending.push_back(make_tri(mn, mn, mn, mx, mn, mn, mn, mn, mx));
    tri_pending.push_back(make_tri(mn, mn, mn, mn, mx, mn, mn, mn, mx));
    tri_pending.push_back(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
    tri_pending.push_back(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
    tri_pending.push_back(make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn));
    tri_pending.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    tri_pending.push_back(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    tri_pending.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));        // collinear
    tri_pending.push_back(make_tri(5, 6, 7, 5, 6, 7, 9, 1, 3));        // repeated vertex
    tri_pending.push_back(make_tri(mn, mn, mn, 0, 0, 0, mx, mx, mx));  // collinear
    tri_pending.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, mx, 0));      // very thin
    tri_pending.push_back(make_tri(0, 0, 0, 1, 1, 0, 1, 0, 1));
    tri_pending.push_back(make_tri(mx, mx, mx, mx, mx, mx, 0, 0, 1));
    tri_pending.push_back(make_tri(-1, -1, -1, 1, 1, -1, 0, -1, 1));
    // random: full range and mixed scales, some degenerate shapes
    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(9);
      span = (k < 4) ? COORD_W : $urandom_range(22, 1);
      ax = $signed(rnd_coord(span)); ay = $signed(rnd_coord(span));
      az = $signed(rnd_coord(span));
      if (k == 9) begin
        // collinear or repeated vertex
        dx = $signed(rnd_coord(8)); dy = $signed(rnd_coord(8));
        dz = $signed(rnd_coord(8));
        tri_pending.push_back(make_tri(ax, ay, az, ax + dx, ay + dy, az + dz,
          ax + 2 * dx, ay + 2 * dy, az + 2 * dz));
      end else begin
        tri_pending.push_back(make_tri(ax, ay, az,
          $signed(rnd_coord(span)), $signed(rnd_coord(span)), $signed(rnd_coord(span)),
          $signed(rnd_coord(span)), $signed(rnd_coord(span)), $signed(rnd_coord(span))));
      end
    end
    n_total = tri_pending.size();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (n_taken == n_total);
    wait (setup_expected.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_bad == 0 && setup_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tsna_pkg.sv
sv/tsna_sqrt.sv
sv/tsna_div.sv
sv/triangle_setup_normal_area.sv
tb/tb.sv
